[hw/rtl/bmp_v3_stream_decoder_core_macros.svh]
// Assertion macros shared by the bitmap decoder RTL.
`ifndef BMP_V3_STREAM_DECODER_CORE_MACROS_SVH
`define BMP_V3_STREAM_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clk edge outside reset (clk and rst_n come from the using scope).
`define BMPV3_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clk edge, reset included.
`define BMPV3_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BMPV3_CHECK(lbl, prop, msg)
`define BMPV3_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/bmpv3_pkg.sv]
// Types and constants shared by the bitmap stream decoder.
`timescale 1ns / 1ps
package bmpv3_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PALETTE,
    PH_PIXELS
  } phase_t;

  typedef enum logic [2:0] {
    SQ_TAKE,
    SQ_EXEC,
    SQ_MUL_ROW,
    SQ_MUL_BASE,
    SQ_SUMMARY
  } seq_t;

  typedef enum logic [1:0] {
    KIND_SUMMARY,
    KIND_PALETTE,
    KIND_PIXEL,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TYPE,
    ERR_INFO_SIZE,
    ERR_COMPRESSED
  } err_t;

  typedef struct packed {
    kind_t       kind;
    err_t        error_code;
    logic [31:0] position;
    logic [23:0] value;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [15:0] bits_per_pixel;
    logic [31:0] color_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_load_t;

  // Header byte offsets at which a little-endian field is complete
  localparam logic [5:0] OFF_TYPE      = 6'd1;
  localparam logic [5:0] OFF_DATA_OFS  = 6'd13;
  localparam logic [5:0] OFF_INFO_SIZE = 6'd17;
  localparam logic [5:0] OFF_WIDTH     = 6'd21;
  localparam logic [5:0] OFF_HEIGHT    = 6'd25;
  localparam logic [5:0] OFF_DEPTH     = 6'd29;
  localparam logic [5:0] OFF_COMPRESS  = 6'd33;
  localparam logic [5:0] OFF_COLORS    = 6'd49;
  localparam logic [5:0] OFF_LAST      = 6'd53;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
  localparam logic [31:0] HDR_BYTES     = 32'd54;
  localparam logic [15:0] DEPTH_RGB     = 16'd24;

  localparam int unsigned OUT_TDATA_W = 176;

endpackage

[hw/rtl/bmpv3_mul.sv]
// Shared 32x32 multiplier, low word of the product registered.
`timescale 1ns / 1ps
module bmpv3_mul (
  input  logic        clk,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] prod_o
);

  logic [31:0] prod_r;
  logic [31:0] prod_nxt;

  assign prod_nxt = a_i * b_i;  // wraps at 32 bits

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod_o = prod_r;

endmodule

[hw/rtl/bmpv3_obuf.sv]
// Output register that holds one result transaction until it is taken.
`timescale 1ns / 1ps
module bmpv3_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  bmpv3_pkg::res_load_t ld_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bmpv3_pkg::result_t  res_o
);
  import bmpv3_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free_o = !valid_r || out_ready_i;

  always_comb begin
    if (ld_i.valid && free_o) begin
      valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_i.valid && free_o) begin
      res_r <= ld_i.res;
    end
  end

  assign out_valid_o = valid_r;
  assign res_o       = res_r;

endmodule

[hw/rtl/bmp_v3_stream_decoder_core.sv]
// Top level of the streaming bitmap (40-byte info header) decoder.
//
//  channel | dir | tdata                          | tuser        | tlast
//  --------+-----+--------------------------------+--------------+-----------
//  in_     | in  | [7:0] file byte                | first_byte   | -
//  out_    | out | error_code, position, value,   | [1:0] kind   | last pixel
//          |     | width, height, bpp, colors     |              | or error
//
// Steps: a file byte is accepted, then executed. Header byte 53 is accepted,
//   executed, then makes two passes through the shared multiplier
//   (width*depth, then (height-1)*row_length) and ends in the summary step.
// Stalls: a cycle that must emit a result waits while the output register is
//   full and not taken; the input stays not ready meanwhile.
// Reset: synchronous, active low; parse goes idle, all counters and header
//   fields clear. No clearing pass is needed.
`timescale 1ns / 1ps
module bmp_v3_stream_decoder_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tuser,   // [0] first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [bmpv3_pkg::OUT_TDATA_W-1:0] out_tdata,
                                   // [1:0] error_code, [33:2] position, [57:34] value,
                                   // [89:58] image_width, [121:90] image_height,
                                   // [137:122] bits_per_pixel, [169:138] color_count,
                                   // [175:170] zero
  output logic [1:0]   out_tuser,  // [1:0] kind
  output logic         out_tlast
);
  import bmpv3_pkg::*;

  // Sequencer and parse state
  seq_t        seq_r, seq_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [5:0]  hdr_off_r, hdr_off_nxt;
  logic [31:0] fshift_r, fshift_nxt;
  // Header fields
  logic [31:0] pdo_r, pdo_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] colors_r, colors_nxt;
  // Palette and pixel walk
  logic [31:0] pal_cnt_r, pal_cnt_nxt;
  logic [1:0]  entry_r, entry_nxt;
  logic [31:0] row_len_r, row_len_nxt;
  logic [31:0] pad_len_r, pad_len_nxt;
  logic [31:0] col_r, col_nxt;
  logic [31:0] rows_left_r, rows_left_nxt;
  logic [31:0] row_base_r, row_base_nxt;

  // Datapath helpers
  logic [31:0] fs_new;
  logic [31:0] col_inc;
  logic [31:0] pal_inc;
  logic [31:0] rl_calc;
  logic [31:0] pad_calc;
  logic [31:0] mul_a, mul_b, mul_prod;

  // Result handoff
  logic        want_emit;
  logic        hold;
  logic        obuf_free;
  result_t     res;
  res_load_t   ld;
  result_t     out_res;

  assign fs_new   = {byte_r, fshift_r[31:8]};
  assign col_inc  = col_r + 32'd1;
  assign pal_inc  = pal_cnt_r + 32'd1;
  // row_length = (width*depth)/8 on the wrapped product
  assign rl_calc  = {3'b000, mul_prod[31:3]};
  // round up to a multiple of 4, wrapping
  assign pad_calc = (rl_calc[1:0] != 2'b00) ? {rl_calc[31:2] + 30'd1, 2'b00} : rl_calc;

  bmpv3_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  always_comb begin
    seq_nxt       = seq_r;
    phase_nxt     = phase_r;
    byte_nxt      = byte_r;
    hdr_off_nxt   = hdr_off_r;
    fshift_nxt    = fshift_r;
    pdo_nxt       = pdo_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    depth_nxt     = depth_r;
    colors_nxt    = colors_r;
    pal_cnt_nxt   = pal_cnt_r;
    entry_nxt     = entry_r;
    row_len_nxt   = row_len_r;
    pad_len_nxt   = pad_len_r;
    col_nxt       = col_r;
    rows_left_nxt = rows_left_r;
    row_base_nxt  = row_base_r;

    mul_a = width_r;
    mul_b = {16'h0000, depth_r};

    want_emit          = 1'b0;
    res.kind           = KIND_SUMMARY;
    res.error_code     = ERR_NONE;
    res.position       = 32'd0;
    res.value          = 24'd0;
    res.image_width    = width_r;
    res.image_height   = height_r;
    res.bits_per_pixel = depth_r;
    res.color_count    = colors_r;
    res.last           = 1'b0;

    in_tready = (seq_r == SQ_TAKE);

    unique case (seq_r)
      SQ_TAKE: begin
        if (in_tvalid) begin
          byte_nxt = in_tdata;
          seq_nxt  = SQ_EXEC;
          if (in_tuser) begin
            // new file: restart the parse from a clean slate
            phase_nxt     = PH_HEADER;
            hdr_off_nxt   = 6'd0;
            fshift_nxt    = 32'd0;
            pdo_nxt       = 32'd0;
            width_nxt     = 32'd0;
            height_nxt    = 32'd0;
            depth_nxt     = 16'd0;
            colors_nxt    = 32'd0;
            pal_cnt_nxt   = 32'd0;
            entry_nxt     = 2'd0;
            row_len_nxt   = 32'd0;
            pad_len_nxt   = 32'd0;
            col_nxt       = 32'd0;
            rows_left_nxt = 32'd0;
            row_base_nxt  = 32'd0;
          end
        end
      end

      SQ_EXEC: begin
        seq_nxt = SQ_TAKE;
        unique case (phase_r)
          PH_HEADER: begin
            fshift_nxt  = fs_new;
            hdr_off_nxt = hdr_off_r + 6'd1;
            unique case (hdr_off_r)
              OFF_TYPE: begin
                if (fs_new[31:16] != BMP_SIGNATURE) begin
                  want_emit      = 1'b1;
                  res.error_code = ERR_TYPE;
                end
              end
              OFF_DATA_OFS:  pdo_nxt = fs_new;
              OFF_INFO_SIZE: begin
                if (fs_new != INFO_HDR_SIZE) begin
                  want_emit      = 1'b1;
                  res.error_code = ERR_INFO_SIZE;
                end
              end
              OFF_WIDTH:  width_nxt  = fs_new;
              OFF_HEIGHT: height_nxt = fs_new;
              OFF_DEPTH:  depth_nxt  = fs_new[31:16];
              OFF_COMPRESS: begin
                if (fs_new != 32'd0) begin
                  want_emit      = 1'b1;
                  res.error_code = ERR_COMPRESSED;
                end
              end
              OFF_COLORS: colors_nxt = fs_new;
              OFF_LAST:   seq_nxt    = SQ_MUL_ROW;
              default: ;
            endcase
            if (want_emit) begin
              // header check failed
              res.kind  = KIND_ERROR;
              res.last  = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end

          PH_PALETTE: begin
            fshift_nxt = fs_new;
            if (entry_r != 2'd3) begin
              entry_nxt = entry_r + 2'd1;
            end else begin
              entry_nxt    = 2'd0;
              pal_cnt_nxt  = pal_inc;
              want_emit    = 1'b1;
              res.kind     = KIND_PALETTE;
              res.position = pal_cnt_r;
              res.value    = fs_new[23:0];
              if (pal_inc == colors_r) begin
                col_nxt   = 32'd0;
                phase_nxt = (rows_left_r == 32'd0 || pad_len_r == 32'd0) ? PH_IDLE
                                                                         : PH_PIXELS;
              end
            end
          end

          PH_PIXELS: begin
            if (col_r < row_len_r) begin
              want_emit    = 1'b1;
              res.kind     = KIND_PIXEL;
              res.position = row_base_r + col_r;
              res.value    = {16'h0000, byte_r};
              res.last     = (rows_left_r == 32'd1) && (col_inc == row_len_r);
            end
            if (col_inc == pad_len_r) begin
              // end of stored row, padding included
              col_nxt       = 32'd0;
              rows_left_nxt = rows_left_r - 32'd1;
              row_base_nxt  = row_base_r - row_len_r;
              if (rows_left_r == 32'd1) begin
                phase_nxt = PH_IDLE;
              end
            end else begin
              col_nxt = col_inc;
            end
          end

          PH_IDLE: ;  // stray byte, dropped
          default: ;
        endcase
      end

      SQ_MUL_ROW: begin
        // multiplier takes width*depth; a zero colour count on a non-24-bit image is derived from the offset
        if (depth_r != DEPTH_RGB && colors_r == 32'd0) begin
          colors_nxt = (pdo_r - HDR_BYTES) >> 2;
        end
        seq_nxt = SQ_MUL_BASE;
      end

      SQ_MUL_BASE: begin
        row_len_nxt = rl_calc;
        pad_len_nxt = pad_calc;
        mul_a       = height_r - 32'd1;
        mul_b       = rl_calc;
        seq_nxt     = SQ_SUMMARY;
      end

      SQ_SUMMARY: begin
        // same operands again so a stalled summary keeps the base address
        mul_a         = height_r - 32'd1;
        mul_b         = row_len_r;
        row_base_nxt  = mul_prod;
        rows_left_nxt = height_r;
        pal_cnt_nxt   = 32'd0;
        entry_nxt     = 2'd0;
        fshift_nxt    = 32'd0;
        if (depth_r != DEPTH_RGB && colors_r != 32'd0) begin
          phase_nxt = PH_PALETTE;
        end else begin
          col_nxt   = 32'd0;
          phase_nxt = (height_r == 32'd0 || pad_len_r == 32'd0) ? PH_IDLE : PH_PIXELS;
        end
        want_emit = 1'b1;
        res.kind  = KIND_SUMMARY;
        seq_nxt   = SQ_TAKE;
      end

      default: seq_nxt = SQ_TAKE;
    endcase
  end

  // A cycle with a result waits for room in the output register.
  assign hold     = want_emit && !obuf_free;
  assign ld.valid = want_emit && obuf_free;
  assign ld.res   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_TAKE;
      phase_r     <= PH_IDLE;
      byte_r      <= 8'd0;
      hdr_off_r   <= 6'd0;
      fshift_r    <= 32'd0;
      pdo_r       <= 32'd0;
      width_r     <= 32'd0;
      height_r    <= 32'd0;
      depth_r     <= 16'd0;
      colors_r    <= 32'd0;
      pal_cnt_r   <= 32'd0;
      entry_r     <= 2'd0;
      row_len_r   <= 32'd0;
      pad_len_r   <= 32'd0;
      col_r       <= 32'd0;
      rows_left_r <= 32'd0;
      row_base_r  <= 32'd0;
    end else if (!hold) begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      byte_r      <= byte_nxt;
      hdr_off_r   <= hdr_off_nxt;
      fshift_r    <= fshift_nxt;
      pdo_r       <= pdo_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      depth_r     <= depth_nxt;
      colors_r    <= colors_nxt;
      pal_cnt_r   <= pal_cnt_nxt;
      entry_r     <= entry_nxt;
      row_len_r   <= row_len_nxt;
      pad_len_r   <= pad_len_nxt;
      col_r       <= col_nxt;
      rows_left_r <= rows_left_nxt;
      row_base_r  <= row_base_nxt;
    end
  end

  bmpv3_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld_i        (ld),
    .free_o      (obuf_free),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .res_o       (out_res)
  );

  assign out_tdata = {6'b000000, out_res.color_count, out_res.bits_per_pixel,
                      out_res.image_height, out_res.image_width, out_res.value,
                      out_res.position, out_res.error_code};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

`include "bmp_v3_stream_decoder_core_macros.svh"

  `BMPV3_CHECK(a_take_then_exec, (in_tvalid && in_tready) |=> (seq_r == SQ_EXEC), "accepted byte not executed next cycle")
  `BMPV3_CHECK(a_pixel_walk_live, (phase_r == PH_PIXELS) |-> (rows_left_r != 32'd0 && pad_len_r != 32'd0), "pixel phase with no rows or empty row")
  `BMPV3_CHECK(a_entry_in_palette, (entry_r != 2'd0) |-> (phase_r == PH_PALETTE), "palette byte index left over outside palette")
  `BMPV3_CHECK(a_last_on_final_row, (ld.valid && ld.res.last) |-> (ld.res.kind == KIND_ERROR || rows_left_r == 32'd1), "last flag outside final row")

endmodule
